[hw/rtl/ufph_pkg.sv]
package ufph_pkg;

    localparam int IDX_W = 10;
    localparam int SIZE_W = 11;
    localparam int IDX_COUNT = 1 << IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHK_CUR,
        ST_CHK_UP,
        ST_LINK_CHILD,
        ST_LINK_ROOT,
        ST_DONE
    } state_t;

endpackage

[hw/rtl/ufph_ram.sv]
module ufph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/union_find_path_halving_top.sv]
// Each request finds the first root and then the second; a pair already joined goes to the
// result, a merge writes the child and then the root; an out-of-range index skips the search.
// Each path-halving hop is one read of the node and then one read of its parent in the store.
// The next request is taken in the cycle after a result is loaded, so no new pair is taken
// before the last is through; a waiting result stalls the next pair once it has finished.
// Reset: a clearing pass writes every store entry (at most 1024), one per cycle, first.
module union_find_path_halving_top #(
    parameter int ELEMENT_COUNT = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ufph_pkg::IDX_W-1:0]   first_index,
    input  logic [ufph_pkg::IDX_W-1:0]   second_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         merged,
    output logic [ufph_pkg::IDX_W-1:0]   first_root,
    output logic [ufph_pkg::IDX_W-1:0]   second_root,
    output logic [ufph_pkg::SIZE_W-1:0]  joined_size
);

    // Only elements that an index can name need storage.
    localparam int DEPTH = (ELEMENT_COUNT < ufph_pkg::IDX_COUNT) ? ELEMENT_COUNT
                                                                  : ufph_pkg::IDX_COUNT;
    localparam int AW = $clog2(DEPTH);
    localparam int SW = ufph_pkg::SIZE_W;
    localparam int IW = ufph_pkg::IDX_W;
    localparam int DW = SW + AW;

    ufph_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          second_reg, second_next;
    logic          out_valid_reg, out_valid_next;

    logic [AW-1:0] cur_reg, cur_next;
    logic [SW-1:0] cur_size_reg, cur_size_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [SW-1:0] size_a_reg, size_a_next;
    logic [AW-1:0] child_reg, child_next;
    logic [AW-1:0] root_reg, root_next;
    logic [SW-1:0] child_size_reg, child_size_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic          res_merged_reg, res_merged_next;
    logic [IW-1:0] res_first_reg, res_first_next;
    logic [IW-1:0] res_second_reg, res_second_next;
    logic [SW-1:0] res_size_reg, res_size_next;
    logic          merged_reg, merged_next;
    logic [IW-1:0] first_root_reg, first_root_next;
    logic [IW-1:0] second_root_reg, second_root_next;
    logic [SW-1:0] joined_size_reg, joined_size_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    logic [AW-1:0] rd_parent;
    logic [SW-1:0] rd_size;
    logic          in_range;
    logic [SW-1:0] sum_wide;

    assign rd_parent = rd_data[AW-1:0];
    assign rd_size = rd_data[DW-1:AW];
    assign in_range = (32'(first_index) < 32'(ELEMENT_COUNT))
                   && (32'(second_index) < 32'(ELEMENT_COUNT));

    ufph_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        second_next = second_reg;
        out_valid_next = out_valid_reg;
        cur_next = cur_reg;
        cur_size_next = cur_size_reg;
        b_next = b_reg;
        ra_next = ra_reg;
        size_a_next = size_a_reg;
        child_next = child_reg;
        root_next = root_reg;
        child_size_next = child_size_reg;
        sum_next = sum_reg;
        res_merged_next = res_merged_reg;
        res_first_next = res_first_reg;
        res_second_next = res_second_reg;
        res_size_next = res_size_reg;
        merged_next = merged_reg;
        first_root_next = first_root_reg;
        second_root_next = second_root_reg;
        joined_size_next = joined_size_reg;
        wr_en = 1'b0;
        wr_addr = cur_reg;
        wr_data = {cur_size_reg, cur_reg};
        rd_en = 1'b0;
        rd_addr = cur_reg;
        in_ready = 1'b0;
        // Sizes never exceed the element count, so the sum fits the size field.
        sum_wide = size_a_reg + rd_size;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ufph_pkg::ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = {SW'(1), clr_cnt_reg};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ufph_pkg::ST_IDLE;
                end
            end
            ufph_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_range)
                    begin
                        cur_next = first_index[AW-1:0];
                        b_next = second_index[AW-1:0];
                        second_next = 1'b0;
                        rd_en = 1'b1;
                        rd_addr = first_index[AW-1:0];
                        state_next = ufph_pkg::ST_CHK_CUR;
                    end
                    else
                    begin
                        res_merged_next = 1'b0;
                        res_first_next = first_index;
                        res_second_next = second_index;
                        res_size_next = '0;
                        state_next = ufph_pkg::ST_DONE;
                    end
                end
            end
            ufph_pkg::ST_CHK_CUR:
            begin
                cur_size_next = rd_size;
                if (rd_parent == cur_reg)
                begin
                    if (!second_reg)
                    begin
                        ra_next = cur_reg;
                        size_a_next = rd_size;
                        second_next = 1'b1;
                        cur_next = b_reg;
                        rd_en = 1'b1;
                        rd_addr = b_reg;
                    end
                    else
                    begin
                        // Second root found; sizes of both roots are known now.
                        res_first_next = IW'(ra_reg);
                        res_second_next = IW'(cur_reg);
                        sum_next = sum_wide[SW-1:0];
                        if (ra_reg == cur_reg)
                        begin
                            res_merged_next = 1'b0;
                            res_size_next = size_a_reg;
                            state_next = ufph_pkg::ST_DONE;
                        end
                        else
                        begin
                            res_merged_next = 1'b1;
                            res_size_next = sum_wide[SW-1:0];
                            if (size_a_reg < rd_size)
                            begin
                                child_next = ra_reg;
                                child_size_next = size_a_reg;
                                root_next = cur_reg;
                            end
                            else
                            begin
                                child_next = cur_reg;
                                child_size_next = rd_size;
                                root_next = ra_reg;
                            end
                            state_next = ufph_pkg::ST_LINK_CHILD;
                        end
                    end
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = rd_parent;
                    state_next = ufph_pkg::ST_CHK_UP;
                end
            end
            ufph_pkg::ST_CHK_UP:
            begin
                // Relink the node to its grandparent and continue from there. In a
                // forest the grandparent never equals the node, so the read below
                // never meets the write in the same entry.
                wr_en = 1'b1;
                wr_addr = cur_reg;
                wr_data = {cur_size_reg, rd_parent};
                cur_next = rd_parent;
                rd_en = 1'b1;
                rd_addr = rd_parent;
                state_next = ufph_pkg::ST_CHK_CUR;
            end
            ufph_pkg::ST_LINK_CHILD:
            begin
                wr_en = 1'b1;
                wr_addr = child_reg;
                wr_data = {child_size_reg, root_reg};
                state_next = ufph_pkg::ST_LINK_ROOT;
            end
            ufph_pkg::ST_LINK_ROOT:
            begin
                wr_en = 1'b1;
                wr_addr = root_reg;
                wr_data = {sum_reg, root_reg};
                state_next = ufph_pkg::ST_DONE;
            end
            ufph_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    merged_next = res_merged_reg;
                    first_root_next = res_first_reg;
                    second_root_next = res_second_reg;
                    joined_size_next = res_size_reg;
                    state_next = ufph_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ufph_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ufph_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            second_reg <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        cur_size_reg <= cur_size_next;
        b_reg <= b_next;
        ra_reg <= ra_next;
        size_a_reg <= size_a_next;
        child_reg <= child_next;
        root_reg <= root_next;
        child_size_reg <= child_size_next;
        sum_reg <= sum_next;
        res_merged_reg <= res_merged_next;
        res_first_reg <= res_first_next;
        res_second_reg <= res_second_next;
        res_size_reg <= res_size_next;
        merged_reg <= merged_next;
        first_root_reg <= first_root_next;
        second_root_reg <= second_root_next;
        joined_size_reg <= joined_size_next;
    end

    assign out_valid = out_valid_reg;
    assign merged = merged_reg;
    assign first_root = first_root_reg;
    assign second_root = second_root_reg;
    assign joined_size = joined_size_reg;

endmodule
